>>> hw/rtl/h2r_pkg.sv
// Shared constants and helpers for the HSL to RGB color converter.
`default_nettype none

package h2r_pkg;

    localparam int HUE_W = 15;
    localparam int CH_W  = 13;
    localparam int F_W   = 12;
    localparam int SEC_W = 3;

    localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
    localparam logic [F_W-1:0]   SECTOR_LEN = 12'd3840;
    localparam int               SECTOR_CNT = 6;

    // A 60-degree sector is 15 times 256 counts.
    localparam int SECTOR_SHIFT = 8;
    localparam int SECTOR_ODD   = 15;

    typedef enum logic [SEC_W-1:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
        logic [HUE_W-1:0] base;
        begin
            case (sec)
                SEC_RY:  base = 15'd0;
                SEC_YG:  base = 15'd3840;
                SEC_GC:  base = 15'd7680;
                SEC_CB:  base = 15'd11520;
                SEC_BM:  base = 15'd15360;
                SEC_MR:  base = 15'd19200;
                default: base = 15'd0;
            endcase
            return base;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hsl_to_rgb.sv
// Pipelined HSL to RGB color converter, one color per beat.
// Each accepted input beat passes through every stage register in turn to its output beat.
// Throughput: one beat per cycle; each of the five stages holds one beat and
// stalls only when the stage behind it is full and the output is not taken.
// The two multipliers and the reciprocal multiply set the stage boundaries.
// Reset clears all stage valid flags; payload registers are not reset.
`default_nettype none

module hsl_to_rgb
    import h2r_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire        [HUE_W-1:0] hue,
    input  wire        [CH_W-1:0]  saturation,
    input  wire        [CH_W-1:0]  lightness,
    output logic                   out_valid,
    input  wire                    out_ready,
    output logic       [CH_W-1:0]  red,
    output logic       [CH_W-1:0]  green,
    output logic       [CH_W-1:0]  blue
);

    localparam int CW  = FRAC_BITS + 1;
    localparam int WW  = (CW > CH_W) ? CW : CH_W;
    localparam int PW  = CW + F_W;
    localparam int NW  = PW - SECTOR_SHIFT;
    localparam int K   = NW + 4;
    localparam int MW  = NW + 1;
    localparam int QW  = NW + MW;
    localparam logic [CW-1:0] ONE   = CW'(1) << FRAC_BITS;
    localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;
    localparam logic [MW-1:0] RECIP =
        MW'((64'd1 << K) / 64'(SECTOR_ODD) + 64'd1);

    // Stage valid flags and per-stage ready.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: clamp inputs, wrap the hue and find sector and offset.
    logic [WW-1:0]    s_wide, l_wide;
    logic [CW-1:0]    s1_s_next, s1_l_next;
    logic [HUE_W-1:0] h_wrap, pos;
    logic [SEC_W-1:0] sec_cnt;
    sector_t          s1_sec_next;
    logic [F_W-1:0]   s1_f_next;

    always_comb
    begin
        s_wide    = WW'(saturation);
        l_wide    = WW'(lightness);
        s1_s_next = (s_wide > ONE_W) ? ONE : s_wide[CW-1:0];
        s1_l_next = (l_wide > ONE_W) ? ONE : l_wide[CW-1:0];
        h_wrap    = (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
        sec_cnt   = '0;
        for (int k = 1; k < SECTOR_CNT; k++)
        begin
            if (h_wrap >= HUE_W'(k) * HUE_SECTOR)
                sec_cnt = sec_cnt + SEC_W'(1);
        end
        s1_sec_next = sector_t'(sec_cnt);
        pos         = h_wrap - sector_base(s1_sec_next);
        s1_f_next   = sec_cnt[0] ? SECTOR_LEN - pos[F_W-1:0] : pos[F_W-1:0];
    end

    logic [CW-1:0]  s1_s_reg, s1_l_reg;
    sector_t        s1_sec_reg;
    logic [F_W-1:0] s1_f_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_s_reg   <= s1_s_next;
            s1_l_reg   <= s1_l_next;
            s1_sec_reg <= s1_sec_next;
            s1_f_reg   <= s1_f_next;
        end
    end

    // Stage 2: chroma.
    logic [CW:0]     two_l;
    logic [CW:0]     l_dev;
    logic [CW-1:0]   one_m_d;
    logic [2*CW-1:0] c_prod;
    logic [CW-1:0]   s2_c_next;

    always_comb
    begin
        two_l     = {s1_l_reg, 1'b0};
        l_dev     = (two_l >= {1'b0, ONE}) ? two_l - {1'b0, ONE} : {1'b0, ONE} - two_l;
        one_m_d   = ONE - l_dev[CW-1:0];
        c_prod    = (2*CW)'(one_m_d) * (2*CW)'(s1_s_reg);
        s2_c_next = c_prod[FRAC_BITS +: CW];
    end

    logic [CW-1:0]  s2_c_reg, s2_l_reg;
    sector_t        s2_sec_reg;
    logic [F_W-1:0] s2_f_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_c_reg   <= s2_c_next;
            s2_l_reg   <= s1_l_reg;
            s2_sec_reg <= s1_sec_reg;
            s2_f_reg   <= s1_f_reg;
        end
    end

    // Stage 3: chroma times hue offset, and the lightness offset m.
    logic [PW-1:0] s3_p_next;
    logic [CW-1:0] s3_m_next;

    assign s3_p_next = PW'(s2_c_reg) * PW'(s2_f_reg);
    assign s3_m_next = s2_l_reg - (s2_c_reg >> 1);

    logic [PW-1:0] s3_p_reg;
    logic [CW-1:0] s3_c_reg, s3_m_reg;
    sector_t       s3_sec_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_p_reg   <= s3_p_next;
            s3_c_reg   <= s2_c_reg;
            s3_m_reg   <= s3_m_next;
            s3_sec_reg <= s2_sec_reg;
        end
    end

    // Stage 4: divide by the sector length as a shift and a reciprocal multiply.
    logic [NW-1:0] n_val;
    logic [QW-1:0] q_prod;
    logic [CW-1:0] s4_x_next;

    always_comb
    begin
        n_val     = s3_p_reg[PW-1:SECTOR_SHIFT];
        q_prod    = QW'(n_val) * QW'(RECIP);
        s4_x_next = q_prod[K +: CW];
    end

    logic [CW-1:0] s4_x_reg, s4_c_reg, s4_m_reg;
    sector_t       s4_sec_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_x_reg   <= s4_x_next;
            s4_c_reg   <= s3_c_reg;
            s4_m_reg   <= s3_m_reg;
            s4_sec_reg <= s3_sec_reg;
        end
    end

    // Stage 5: place components by sector, add m and clamp to 1.0.
    logic [CW-1:0] rc, gc, bc;
    logic [CW:0]   r_sum, g_sum, b_sum;
    logic [WW-1:0] r_w, g_w, b_w;
    logic [CH_W-1:0] red_next, green_next, blue_next;

    always_comb
    begin
        case (s4_sec_reg)
            SEC_RY:  begin rc = s4_c_reg; gc = s4_x_reg; bc = '0;       end
            SEC_YG:  begin rc = s4_x_reg; gc = s4_c_reg; bc = '0;       end
            SEC_GC:  begin rc = '0;       gc = s4_c_reg; bc = s4_x_reg; end
            SEC_CB:  begin rc = '0;       gc = s4_x_reg; bc = s4_c_reg; end
            SEC_BM:  begin rc = s4_x_reg; gc = '0;       bc = s4_c_reg; end
            default: begin rc = s4_c_reg; gc = '0;       bc = s4_x_reg; end
        endcase
        r_sum      = {1'b0, rc} + {1'b0, s4_m_reg};
        g_sum      = {1'b0, gc} + {1'b0, s4_m_reg};
        b_sum      = {1'b0, bc} + {1'b0, s4_m_reg};
        r_w        = WW'((r_sum > {1'b0, ONE}) ? ONE : r_sum[CW-1:0]);
        g_w        = WW'((g_sum > {1'b0, ONE}) ? ONE : g_sum[CW-1:0]);
        b_w        = WW'((b_sum > {1'b0, ONE}) ? ONE : b_sum[CW-1:0]);
        red_next   = r_w[CH_W-1:0];
        green_next = g_w[CH_W-1:0];
        blue_next  = b_w[CH_W-1:0];
    end

    logic [CH_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire

>>> test/hsl_to_rgb_tb.sv
// Self-checking testbench for the HSL to RGB converter: directed and random beats.
module hsl_to_rgb_tb
    import h2r_pkg::*;
();

    localparam int ONE_VAL      = 1 << F_W;
    localparam int RANDOM_BEATS = 1900;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 999;
    localparam int DRAIN_AT     = 1300;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ROW_CNT      = 23;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  light;
        bit               typed;
        rgb_t             rgb;
    } color_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [HUE_W-1:0] hue = '0;
    logic [CH_W-1:0]  saturation = '0;
    logic [CH_W-1:0]  lightness = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    rgb_t       expected_rgb[$];
    color_row_t color_rows[ROW_CNT];
    bit         calm = 1'b0;
    int         results_seen = 0;
    int         fails = 0;
    int         cycles = 0;

    hsl_to_rgb u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #4 clk = ~clk;

    function automatic logic [31:0] clamp_one(input logic [31:0] v);
        return (v > ONE_VAL) ? ONE_VAL : v;
    endfunction

    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] h_in,
                                         input logic [CH_W-1:0] s_in,
                                         input logic [CH_W-1:0] l_in);
        logic [31:0] h, s, l, two_l, d, c, sec_idx, pos, f, x, m;
        logic [31:0] rc, gc, bc;
        sector_t     sec;
        rgb_t        res;
        h = (h_in >= HUE_FULL) ? 32'(h_in - HUE_FULL) : 32'(h_in);
        s = clamp_one(32'(s_in));
        l = clamp_one(32'(l_in));
        two_l = l * 2;
        d = (two_l >= ONE_VAL) ? two_l - ONE_VAL : ONE_VAL - two_l;
        c = ((ONE_VAL - d) * s) >> F_W;
        sec_idx = h / HUE_SECTOR;
        pos = h % HUE_SECTOR;
        f = sec_idx[0] ? HUE_SECTOR - pos : pos;
        x = (c * f) / HUE_SECTOR;
        m = l - (c >> 1);
        sec = sector_t'(sec_idx[SEC_W-1:0]);
        case (sec)
            SEC_RY:
            begin
                rc = c; gc = x; bc = 0;
            end
            SEC_YG:
            begin
                rc = x; gc = c; bc = 0;
            end
            SEC_GC:
            begin
                rc = 0; gc = c; bc = x;
            end
            SEC_CB:
            begin
                rc = 0; gc = x; bc = c;
            end
            SEC_BM:
            begin
                rc = x; gc = 0; bc = c;
            end
            default:
            begin
                rc = c; gc = 0; bc = x;
            end
        endcase
        res.red   = CH_W'(clamp_one(rc + m));
        res.green = CH_W'(clamp_one(gc + m));
        res.blue  = CH_W'(clamp_one(bc + m));
        return res;
    endfunction

    function automatic color_row_t make_row(input int h, input int s, input int l,
                                            input bit typed, input int r, input int g,
                                            input int b);
        color_row_t row;
        row.hue       = HUE_W'(h);
        row.sat       = CH_W'(s);
        row.light     = CH_W'(l);
        row.typed     = typed;
        row.rgb.red   = CH_W'(r);
        row.rgb.green = CH_W'(g);
        row.rgb.blue  = CH_W'(b);
        return row;
    endfunction

    task automatic offer_color(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
                               input logic [CH_W-1:0] l, input rgb_t want);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        expected_rgb.insert(expected_rgb.size(), want);
    endtask

    task automatic random_color(output logic [HUE_W-1:0] h, output logic [CH_W-1:0] s,
                                output logic [CH_W-1:0] l);
        int pick;
        int edge_hue;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            h = HUE_W'($urandom_range(23039));
            s = CH_W'($urandom_range(ONE_VAL));
            l = CH_W'($urandom_range(ONE_VAL));
        end
        else if (pick < 80)
        begin
            edge_hue = $urandom_range(5) * 3840 + $urandom_range(2) + 23039;
            h = HUE_W'(edge_hue % 23040);
            case ($urandom_range(3))
                0: s = '0;
                1: s = CH_W'(ONE_VAL);
                2: s = CH_W'(ONE_VAL - 1);
                default: s = CH_W'($urandom_range(ONE_VAL));
            endcase
            case ($urandom_range(4))
                0: l = '0;
                1: l = CH_W'(ONE_VAL);
                2: l = CH_W'(ONE_VAL / 2);
                3: l = CH_W'(ONE_VAL / 2 + $urandom_range(2) - 1);
                default: l = CH_W'($urandom_range(ONE_VAL));
            endcase
        end
        else
        begin
            h = HUE_W'($urandom_range(32767));
            s = CH_W'($urandom_range(8191));
            l = CH_W'($urandom_range(8191));
        end
    endtask

    task automatic compare_field(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin : color_check
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_rgb.size() == 0)
            begin
                $error("beat with no expectation: red %0d green %0d blue %0d",
                       red, green, blue);
                fails++;
            end
            else
            begin
                want = expected_rgb.pop_front();
                compare_field("red", want.red, red);
                compare_field("green", want.green, green);
                compare_field("blue", want.blue, blue);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : color_sink
        int  stall;
        bit  held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (stall = 0; stall < HOLD_CYCLES; stall++)
                    @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 31);
        end
    end

    initial
    begin : color_source
        logic [HUE_W-1:0] h;
        logic [CH_W-1:0]  s;
        logic [CH_W-1:0]  l;
        color_row_t       row;
        int               n;

        color_rows[0]  = make_row(0, 0, 0, 1, 0, 0, 0);
        color_rows[1]  = make_row(0, 4096, 2048, 1, 4096, 0, 0);
        color_rows[2]  = make_row(7680, 4096, 2048, 1, 0, 4096, 0);
        color_rows[3]  = make_row(15360, 4096, 2048, 1, 0, 0, 4096);
        color_rows[4]  = make_row(0, 0, 2048, 1, 2048, 2048, 2048);
        color_rows[5]  = make_row(0, 4096, 4096, 1, 4096, 4096, 4096);
        color_rows[6]  = make_row(0, 8191, 0, 1, 0, 0, 0);
        color_rows[7]  = make_row(0, 0, 8191, 1, 4096, 4096, 4096);
        color_rows[8]  = make_row(23040, 4096, 2048, 1, 4096, 0, 0);
        color_rows[9]  = make_row(1920, 4096, 2048, 0, 0, 0, 0);
        color_rows[10] = make_row(3839, 4096, 2048, 0, 0, 0, 0);
        color_rows[11] = make_row(3840, 4096, 2048, 0, 0, 0, 0);
        color_rows[12] = make_row(11520, 4096, 2048, 0, 0, 0, 0);
        color_rows[13] = make_row(19200, 4096, 2048, 0, 0, 0, 0);
        color_rows[14] = make_row(23039, 4096, 2048, 0, 0, 0, 0);
        color_rows[15] = make_row(32767, 8191, 8191, 0, 0, 0, 0);
        color_rows[16] = make_row(32767, 4096, 2048, 0, 0, 0, 0);
        color_rows[17] = make_row(11519, 2048, 1024, 0, 0, 0, 0);
        color_rows[18] = make_row(5000, 1, 4095, 0, 0, 0, 0);
        color_rows[19] = make_row(20000, 4095, 1, 0, 0, 0, 0);
        color_rows[20] = make_row(1, 4096, 2048, 0, 0, 0, 0);
        color_rows[21] = make_row(16'h5555 & 16'h7fff, 'h0aaa, 'h1555, 0, 0, 0, 0);
        color_rows[22] = make_row('h2aaa, 'h1555, 'h0aaa, 0, 0, 0, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (color_rows[i])
        begin
            row = color_rows[i];
            offer_color(row.hue, row.sat, row.light,
                        row.typed ? row.rgb : predict_rgb(row.hue, row.sat, row.light));
        end

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            if (n == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                while (expected_rgb.size() != 0)
                    @(posedge clk);
            end
            random_color(h, s, l);
            offer_color(h, s, l, predict_rgb(h, s, l));
        end

        in_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
